FILE: hw/rtl/substring_search_line_locator_assert.svh
// assertion macros shared by the rtl
`ifndef SUBSTRING_SEARCH_LINE_LOCATOR_ASSERT_SVH
`define SUBSTRING_SEARCH_LINE_LOCATOR_ASSERT_SVH

// expression must hold at every edge outside reset
`define SSLL_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant violated");

// consequent must hold in the same cycle as the antecedent
`define SSLL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

FILE: hw/rtl/ssll_pkg.sv
package ssll_pkg;

  // pattern store depth and line counter width
  localparam int PATTERN_MAX = 126;
  localparam int LINE_BITS   = 16;

  // derived widths
  localparam int LEN_W    = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int SCROLL_W = 16;

  // input word kinds
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // special characters
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // lines kept above the match when scrolling
  localparam logic [LINE_BITS-1:0] SCROLL_BACK = LINE_BITS'(2);

  typedef logic [7:0]             char_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [SCROLL_W-1:0]    scroll_t;
  typedef logic [PATTERN_MAX-1:0] match_vec_t;

endpackage

FILE: hw/rtl/substring_search_line_locator.sv
// path: an accepted word is held in the input register; its result word (if any)
//   is then loaded into the result register that drives the outputs
// throughput: one word per cycle; all pattern positions are compared in parallel
//   (shift-and), so the only limit is the output stall
// reset: synchronous active-low rst_n clears valids, pattern length, match bits,
//   line counter and done flag; the pattern store is not cleared
module substring_search_line_locator (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  ssll_pkg::char_t        in_data_byte,
  input  logic                   in_first,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_found,
  output ssll_pkg::scroll_t      out_scroll_line
);
  import ssll_pkg::*;

  `include "substring_search_line_locator_assert.svh"

  // input register
  logic  s1_valid_r;
  logic  s1_cmd_r;
  char_t s1_byte_r;
  logic  s1_first_r;
  logic  s1_last_r;

  // search state
  char_t      store_r [PATTERN_MAX];
  len_t       len_r, len_nxt;
  match_vec_t pm_r, pm_nxt;
  line_t      lc_r, lc_nxt;
  logic       done_r, done_nxt;

  // result register
  logic    out_valid_r;
  logic    out_found_r;
  scroll_t out_scroll_r;

  // processing outcome
  logic       advance;
  logic       emit;
  logic       emit_found;
  scroll_t    emit_scroll;
  logic       store_we;
  len_t       base_len;
  match_vec_t len_mask;
  match_vec_t last_onehot;
  match_vec_t base_pm;
  match_vec_t step_pm;
  logic       hit;
  line_t      base_lc;
  logic       base_done;

  // pipeline moves when the result register is free or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r   <= in_cmd;
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_first;
      s1_last_r  <= in_last;
    end
  end

  // position masks for the current pattern length
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      len_mask[k]    = (LEN_W'(k) < len_r);
      last_onehot[k] = (LEN_W'(k + 1) == len_r);
    end
  end

  // shift-and step over all pattern positions
  always_comb begin
    step_pm[0] = len_mask[0] ? (store_r[0] == s1_byte_r) : base_pm[0];
    for (int k = 1; k < PATTERN_MAX; k++) begin
      step_pm[k] = len_mask[k] ? (base_pm[k-1] && (store_r[k] == s1_byte_r)) : base_pm[k];
    end
  end

  assign hit = |(step_pm & last_onehot);

  // restart view of the scan state
  always_comb begin
    if (s1_first_r) begin
      base_pm   = '0;
      base_lc   = '0;
      base_done = 1'b0;
    end else begin
      base_pm   = pm_r;
      base_lc   = lc_r;
      base_done = done_r;
    end
  end

  assign base_len = s1_first_r ? '0 : len_r;

  // next state and result for the word in the input register
  always_comb begin
    len_nxt     = len_r;
    pm_nxt      = pm_r;
    lc_nxt      = lc_r;
    done_nxt    = done_r;
    store_we    = 1'b0;
    emit        = 1'b0;
    emit_found  = 1'b0;
    emit_scroll = '0;
    if (s1_cmd_r == CMD_PATTERN) begin
      // pattern load
      pm_nxt  = '0;
      len_nxt = base_len;
      if ((s1_byte_r != CHAR_NUL) && (base_len < LEN_W'(PATTERN_MAX))) begin
        store_we = 1'b1;
        len_nxt  = base_len + LEN_W'(1);
      end
    end else if (len_r != '0) begin
      // text scan
      pm_nxt   = base_pm;
      lc_nxt   = base_lc;
      done_nxt = base_done;
      if (!base_done) begin
        if (s1_byte_r == CHAR_NUL) begin
          done_nxt = 1'b1;
          emit     = 1'b1;
        end else if (s1_byte_r == CHAR_NEWLINE) begin
          pm_nxt = '0;
          if (base_lc != '1) begin
            lc_nxt = base_lc + LINE_BITS'(1);
          end
          if (s1_last_r) begin
            done_nxt = 1'b1;
            emit     = 1'b1;
          end
        end else begin
          pm_nxt = step_pm;
          if (hit) begin
            done_nxt   = 1'b1;
            emit       = 1'b1;
            emit_found = 1'b1;
            if (base_lc > SCROLL_BACK) begin
              emit_scroll = SCROLL_W'(base_lc - SCROLL_BACK);
            end
          end else if (s1_last_r) begin
            done_nxt = 1'b1;
            emit     = 1'b1;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      pm_r   <= '0;
      lc_r   <= '0;
      done_r <= 1'b0;
    end else if (s1_valid_r && advance) begin
      len_r  <= len_nxt;
      pm_r   <= pm_nxt;
      lc_r   <= lc_nxt;
      done_r <= done_nxt;
    end
  end

  // pattern store, at most one byte written per pattern word (zero bytes and overflow are not stored)
  always_ff @(posedge clk) begin
    if (s1_valid_r && advance && store_we) begin
      store_r[base_len[IDX_W-1:0]] <= s1_byte_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && emit) begin
      out_found_r  <= emit_found;
      out_scroll_r <= emit_scroll;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_scroll_line = out_scroll_r;

  // checks
  `SSLL_ASSERT_ALWAYS(a_pm_within_len, clk, rst_n, (pm_r & ~len_mask) == '0)
  `SSLL_ASSERT_IMPLIES(a_result_sets_done, clk, rst_n, out_valid_r, done_r)
  `SSLL_ASSERT_IMPLIES(a_miss_scroll_zero, clk, rst_n, out_valid_r && !out_found_r, out_scroll_r == '0)

endmodule

FILE: bench/tb_substring_search_line_locator.sv
module tb_substring_search_line_locator;
  timeunit 1ns;
  timeprecision 1ps;

  import ssll_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic  cmd;
    char_t data;
    logic  first;
    logic  last;
  } search_word_t;

  typedef struct packed {
    logic    found;
    scroll_t scroll;
  } hit_report_t;

  logic    clk;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  logic    in_cmd = CMD_PATTERN;
  char_t   in_data_byte = CHAR_NUL;
  logic    in_first = 1'b0;
  logic    in_last = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  logic    out_found;
  scroll_t out_scroll_line;

  // words waiting to be sent and reports waiting to come back
  search_word_t pending_words[$];
  hit_report_t  hit_reports_q[$];
  search_word_t cur_word;

  // shadow of the search state
  char_t      pat_mem[PATTERN_MAX];
  int         pat_len = 0;
  match_vec_t run_bits = '0;
  line_t      line_cnt = '0;
  logic       scan_done = 1'b0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  err_cnt = 0;
  int  gen_cnt = 0;
  int  cycle_cnt = 0;
  int  hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;

  substring_search_line_locator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .in_first        (in_first),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_scroll_line (out_scroll_line)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // shift-and search with line tracking, one accepted word at a time
  task automatic locate_match(input search_word_t w);
    match_vec_t  nxt;
    hit_report_t rep;
    nxt = '0;
    if (w.cmd == CMD_PATTERN) begin
      run_bits = '0;
      if (w.first) pat_len = 0;
      if (w.data != CHAR_NUL && pat_len < PATTERN_MAX) begin
        pat_mem[pat_len] = w.data;
        pat_len++;
      end
      return;
    end
    if (pat_len == 0) return;
    if (w.first) begin
      run_bits  = '0;
      line_cnt  = '0;
      scan_done = 1'b0;
    end
    if (scan_done) return;
    if (w.data == CHAR_NUL) begin
      scan_done = 1'b1;
      rep = '{found: 1'b0, scroll: '0};
      hit_reports_q.push_back(rep);
      return;
    end
    if (w.data == CHAR_NEWLINE) begin
      run_bits = '0;
      if (line_cnt != '1) line_cnt++;
    end else begin
      for (int k = 0; k < pat_len; k++)
        nxt[k] = ((k == 0) ? 1'b1 : run_bits[k-1]) && (pat_mem[k] == w.data);
      run_bits = nxt;
      if (run_bits[pat_len-1]) begin
        scan_done = 1'b1;
        rep.found = 1'b1;
        rep.scroll = scroll_t'((line_cnt > SCROLL_BACK) ? line_cnt - SCROLL_BACK : '0);
        hit_reports_q.push_back(rep);
        return;
      end
    end
    if (w.last) begin
      scan_done = 1'b1;
      rep = '{found: 1'b0, scroll: '0};
      hit_reports_q.push_back(rep);
    end
  endtask

  task automatic put(input logic cmd, input char_t data, input logic first, input logic last);
    search_word_t w;
    w = '{cmd: cmd, data: data, first: first, last: last};
    pending_words.push_back(w);
    gen_cnt++;
  endtask

  function automatic char_t pick_char();
    // small alphabet most of the time so that matches are common
    if ($urandom_range(0, 7) == 0) return char_t'($urandom_range(1, 255));
    return char_t'(8'h61 + $urandom_range(0, 2));
  endfunction

  // random patterns, each followed by a few text runs that often hold it
  task automatic gen_random(input int n);
    char_t pat[$];
    char_t txt[$];
    int    target;
    int    plen;
    int    tlen;
    int    pos;
    int    ending;
    logic  fl;
    target = gen_cnt + n;
    while (gen_cnt < target) begin
      pat.delete();
      if ($urandom_range(0, 14) == 0) begin
        // empty pattern
        put(CMD_PATTERN, CHAR_NUL, 1'b1, 1'($urandom_range(0, 1)));
      end else begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
        for (int k = 0; k < plen; k++) begin
          pat.push_back(pick_char());
          put(CMD_PATTERN, pat[k], k == 0, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 9) == 0) put(CMD_PATTERN, CHAR_NUL, 1'b0, 1'b0);
        end
      end
      repeat ($urandom_range(1, 3)) begin
        txt.delete();
        tlen = $urandom_range(1, 24);
        for (int k = 0; k < tlen; k++)
          txt.push_back(($urandom_range(0, 5) == 0) ? CHAR_NEWLINE : pick_char());
        if (pat.size() != 0 && $urandom_range(0, 2) != 0) begin
          pos = $urandom_range(0, txt.size());
          foreach (pat[j]) txt.insert(pos + j, pat[j]);
        end
        ending = $urandom_range(0, 3);
        if (ending == 1) txt.push_back(CHAR_NUL);
        foreach (txt[k]) begin
          // stray zero pattern word mid-scan clears the partial matches
          if ($urandom_range(0, 39) == 0) begin
            fl = ($urandom_range(0, 7) == 0);
            put(CMD_PATTERN, CHAR_NUL, fl, 1'($urandom_range(0, 1)));
            if (fl) pat.delete();
          end
          put(CMD_TEXT, txt[k], k == 0 || $urandom_range(0, 49) == 0,
              (ending == 0 && k == txt.size() - 1) || $urandom_range(0, 59) == 0);
        end
      end
    end
  endtask

  task automatic drain_all();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || hit_reports_q.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) locate_match(cur_word);
      if (in_valid && in_stall) begin
        // stalled word stays put
      end else if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_word = pending_words.pop_front();
        in_valid     <= 1'b1;
        in_cmd       <= cur_word.cmd;
        in_data_byte <= cur_word.data;
        in_first     <= cur_word.first;
        in_last      <= cur_word.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and result check
  always @(posedge clk) begin
    hit_report_t exp_rep;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hit_reports_q.size() == 0) begin
          $error("unexpected result word: found=%0d scroll_line=%0d",
                 out_found, out_scroll_line);
          err_cnt++;
        end else begin
          exp_rep = hit_reports_q.pop_front();
          if (out_found !== exp_rep.found) begin
            $error("found: expected %0d, got %0d", exp_rep.found, out_found);
            err_cnt++;
          end
          if (out_scroll_line !== exp_rep.scroll) begin
            $error("scroll_line: expected %0d, got %0d", exp_rep.scroll, out_scroll_line);
            err_cnt++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // one long receiver hold-off while the sender keeps going
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL substring_search_line_locator");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // text with no pattern loaded yet
    put(CMD_TEXT, "a", 1'b1, 1'b0);
    // pattern "ab" with a zero byte that must be skipped
    put(CMD_PATTERN, "a", 1'b1, 1'b0);
    put(CMD_PATTERN, CHAR_NUL, 1'b0, 1'b0);
    put(CMD_PATTERN, "b", 1'b0, 1'b0);
    // match on line three, then text after done
    put(CMD_TEXT, "x", 1'b1, 1'b0);
    repeat (3) put(CMD_TEXT, CHAR_NEWLINE, 1'b0, 1'b0);
    put(CMD_TEXT, "a", 1'b0, 1'b0);
    put(CMD_TEXT, "b", 1'b0, 1'b0);
    put(CMD_TEXT, "z", 1'b0, 1'b0);
    // newline splits the match, text ends on last
    put(CMD_TEXT, "a", 1'b1, 1'b0);
    put(CMD_TEXT, CHAR_NEWLINE, 1'b0, 1'b0);
    put(CMD_TEXT, "b", 1'b0, 1'b1);
    // pattern word during a scan, text ends on a zero byte
    put(CMD_TEXT, "a", 1'b1, 1'b0);
    put(CMD_PATTERN, "c", 1'b0, 1'b0);
    put(CMD_TEXT, "b", 1'b0, 1'b0);
    put(CMD_TEXT, "c", 1'b0, 1'b0);
    put(CMD_TEXT, CHAR_NUL, 1'b0, 1'b0);
    // pattern holding a newline never matches
    put(CMD_PATTERN, 8'hFF, 1'b1, 1'b1);
    put(CMD_PATTERN, CHAR_NEWLINE, 1'b0, 1'b0);
    put(CMD_TEXT, 8'hFF, 1'b1, 1'b0);
    put(CMD_TEXT, CHAR_NEWLINE, 1'b0, 1'b0);
    put(CMD_TEXT, CHAR_NUL, 1'b0, 1'b0);
    // match on a word with both first and last set
    put(CMD_PATTERN, 8'h80, 1'b1, 1'b0);
    put(CMD_TEXT, 8'h80, 1'b1, 1'b1);

    // pattern overflow: the last two bytes are dropped
    put(CMD_PATTERN, "q", 1'b1, 1'b0);
    repeat (PATTERN_MAX - 1) put(CMD_PATTERN, "q", 1'b0, 1'b0);
    repeat (2) put(CMD_PATTERN, "r", 1'b0, 1'b0);
    put(CMD_TEXT, "q", 1'b1, 1'b0);
    repeat (PATTERN_MAX - 1) put(CMD_TEXT, "q", 1'b0, 1'b0);
    put(CMD_TEXT, "r", 1'b0, 1'b1);

    // no idling, with the long receiver hold-off near the end
    gen_random(120);
    do @(negedge clk);
    while (pending_words.size() > 100);
    hold_go = 1'b1;
    drain_all();

    // sender idles
    send_idle_pct = 45;
    gen_random(60);
    drain_all();
    gen_random(60);
    drain_all();

    // receiver stalls
    send_idle_pct = 0;
    recv_stall_pct = 45;
    gen_random(120);
    drain_all();

    // both sides idle
    send_idle_pct = 20;
    recv_stall_pct = 20;
    gen_random(120);
    drain_all();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && hit_reports_q.size() == 0) begin
      $display("PASS substring_search_line_locator");
    end else begin
      $display("FAIL substring_search_line_locator");
    end
    $finish;
  end

endmodule
